// ===== hw/rtl/two_sphere_mesh_size_field_defines.svh =====
// ----------------------------------------------------------------------------
// Two-sphere mesh size field: assertion macros
// Shared concurrent checks, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_SPHERE_MESH_SIZE_FIELD_DEFINES_SVH
`define TWO_SPHERE_MESH_SIZE_FIELD_DEFINES_SVH

// same-cycle implication
`define TSM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tsm same-cycle check failed");

// next-cycle implication
`define TSM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tsm next-cycle check failed");

`endif

// ===== hw/rtl/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsm_pkg
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int FRAC_MIN      = 8;

    localparam int PT_W       = 32;
    localparam int SZ_W       = 31;
    localparam int BAND_W     = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIFF_W     = PT_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int RAD_W      = SQ_W + 2;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int DS_W       = SZ_W + BAND_W - FRAC_MIN;
    localparam int PROD_W     = 2 * SZ_W;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CZ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BAND   = 3'd7;

    localparam logic [SZ_W-1:0]   RST_INNER  = 31'd4194304;
    localparam logic [SZ_W-1:0]   RST_OUTER  = 31'd16777216;
    localparam logic [SZ_W-1:0]   RST_FINE   = 31'd503316;
    localparam logic [SZ_W-1:0]   RST_COARSE = 31'd5033165;
    localparam logic [BAND_W-1:0] RST_BAND   = 27'd8388608;

    localparam logic [SZ_W-1:0] SZ_MAX = {SZ_W{1'b1}};

    // live configuration plus derived values
    typedef struct packed {
        logic signed [PT_W-1:0] cx;
        logic signed [PT_W-1:0] cy;
        logic signed [PT_W-1:0] cz;
        logic [SZ_W-1:0]        a;
        logic [SZ_W-1:0]        b;
        logic [SZ_W-1:0]        fine;
        logic [SZ_W-1:0]        coarse;
        logic [SZ_W-1:0]        inner;
        logic [DS_W-1:0]        ds;
    } tsm_cfg_t;

    // classified item: ramp from lo to hi over num, or hi as is
    typedef struct packed {
        logic              is_ramp;
        logic [ROOT_W-1:0] num;
        logic [SZ_W-1:0]   lo;
        logic [SZ_W-1:0]   hi;
    } tsm_item_t;

endpackage

// ===== hw/rtl/two_sphere_mesh_size_field.sv =====
// ----------------------------------------------------------------------------
// two_sphere_mesh_size_field
// Target mesh size for a point between a small sphere and a big sphere.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one point (x,y,z), signed Q8.24, per valid/ready transaction.
//   m_* channel: one mesh_size, unsigned Q7.24, per input transaction, in order.
//   cfg_*: plain write port, index 0..7 selects the register, no read-back.
// Throughput: one transaction per cycle unless a stall or a write holds s_ready.
// Path: the front (differences, squares, sum, 34-stage square root, region
//   register), the queue, and the back (pop register, one stage per fraction
//   bit of the band divider, ramp multiply, result register).
// After reset, and after any register write, s_ready is low while the band
//   width and the inner target (a*coarse/b, one quotient bit a cycle) are
//   recomputed; the division is skipped when b is zero or the target saturates.
// A stalled receiver holds the result register; the back stalls, the queue
//   fills, and then the front stalls and drops s_ready.
// ----------------------------------------------------------------------------
`include "two_sphere_mesh_size_field_defines.svh"

module two_sphere_mesh_size_field #(
    parameter int FRAC_BITS = tsm_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tsm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [tsm_pkg::PT_W-1:0] s_point_x,
    input  logic signed [tsm_pkg::PT_W-1:0] s_point_y,
    input  logic signed [tsm_pkg::PT_W-1:0] s_point_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tsm_pkg::SZ_W-1:0]        m_mesh_size
);
    import tsm_pkg::*;

    tsm_cfg_t  cfg;
    logic      cfg_busy;
    logic      q_push, q_pop, q_full, q_empty;
    tsm_item_t q_in, q_out;

    // register file; derived values settle before items are taken
    tsm_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .cfg_o(cfg), .busy_o(cfg_busy)
    );

    // front: distances and region
    tsm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_point_z(s_point_z),
        .cfg_i(cfg), .busy_i(cfg_busy), .full_i(q_full),
        .push_o(q_push), .item_o(q_in)
    );

    // decoupling queue
    tsm_fifo #(.WIDTH($bits(tsm_item_t)), .DEPTH(FIFO_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .din(q_in),
        .pop(q_pop), .dout(q_out),
        .full(q_full), .empty(q_empty)
    );

    // back: fraction, ramp, output
    tsm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .item_i(q_out), .empty_i(q_empty), .pop_o(q_pop), .ds_i(cfg.ds),
        .m_valid(m_valid), .m_ready(m_ready), .m_mesh_size(m_mesh_size)
    );

    // a register write must hold off new points while derived values update
    `TSM_ASSERT_NXT(a_cfg_holds_input, cfg_wr_en, !s_ready)
    // the front never pushes into a full queue
    `TSM_ASSERT_IMP(a_no_push_full, q_push, !q_full)
    // a push without a pop leaves the queue occupied
    `TSM_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_empty)

endmodule

// ===== hw/rtl/tsm_cfg.sv =====
// ----------------------------------------------------------------------------
// tsm_cfg
// Register file and sequential derivation of band width and inner target.
// ----------------------------------------------------------------------------
module tsm_cfg #(
    parameter int FRAC_BITS = tsm_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tsm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tsm_pkg::tsm_cfg_t               cfg_o,
    output logic                            busy_o
);
    import tsm_pkg::*;

    localparam int BP_W  = BAND_W + SZ_W;
    localparam int CNT_W = $clog2(SZ_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic signed [PT_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [SZ_W-1:0]        a_reg, b_reg, fine_reg, coarse_reg, inner_reg, inner_next;
    logic [BAND_W-1:0]      band_reg;
    logic [DS_W-1:0]        ds_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SZ_W-1:0]        rem_reg, rem_next, dvd_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [1:0]             state_reg, state_next;
    logic [BP_W-1:0]        band_prod;
    logic [SZ_W:0]          rem_sh;
    logic                   qbit;

    assign band_prod = {{SZ_W{1'b0}}, band_reg} * {{BAND_W{1'b0}}, a_reg};
    assign rem_sh    = {rem_reg, dvd_reg[SZ_W-1]};
    assign qbit      = rem_sh >= {1'b0, b_reg};
    assign rem_next  = qbit ? SZ_W'(rem_sh - {1'b0, b_reg}) : rem_sh[SZ_W-1:0];
    assign inner_next = {inner_reg[SZ_W-2:0], qbit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            a_reg      <= RST_INNER;
            b_reg      <= RST_OUTER;
            fine_reg   <= RST_FINE;
            coarse_reg <= RST_COARSE;
            band_reg   <= RST_BAND;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CX:     cx_reg     <= cfg_wdata[PT_W-1:0];
                REG_CY:     cy_reg     <= cfg_wdata[PT_W-1:0];
                REG_CZ:     cz_reg     <= cfg_wdata[PT_W-1:0];
                REG_INNER:  a_reg      <= cfg_wdata[SZ_W-1:0];
                REG_OUTER:  b_reg      <= cfg_wdata[SZ_W-1:0];
                REG_FINE:   fine_reg   <= cfg_wdata[SZ_W-1:0];
                REG_COARSE: coarse_reg <= cfg_wdata[SZ_W-1:0];
                REG_BAND:   band_reg   <= cfg_wdata[BAND_W-1:0];
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_MUL:  state_next = ST_CHK;
            ST_CHK: begin
                if (b_reg == '0 || prod_reg >= {b_reg, {SZ_W{1'b0}}}) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(SZ_W - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // any write restarts the derivation
        if (cfg_wr_en) begin
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_MUL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_MUL: begin
                prod_reg <= {{SZ_W{1'b0}}, a_reg} * {{SZ_W{1'b0}}, coarse_reg};
                ds_reg   <= DS_W'(band_prod >> FRAC_BITS);
            end
            ST_CHK: begin
                cnt_reg <= '0;
                rem_reg <= prod_reg[PROD_W-1:SZ_W];
                dvd_reg <= prod_reg[SZ_W-1:0];
                if (b_reg == '0) begin
                    inner_reg <= '0;
                end else if (prod_reg >= {b_reg, {SZ_W{1'b0}}}) begin
                    inner_reg <= SZ_MAX;
                end
            end
            ST_DIV: begin
                rem_reg   <= rem_next;
                dvd_reg   <= {dvd_reg[SZ_W-2:0], 1'b0};
                inner_reg <= inner_next;
                cnt_reg   <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign busy_o = state_reg != ST_IDLE;

    assign cfg_o.cx     = cx_reg;
    assign cfg_o.cy     = cy_reg;
    assign cfg_o.cz     = cz_reg;
    assign cfg_o.a      = a_reg;
    assign cfg_o.b      = b_reg;
    assign cfg_o.fine   = fine_reg;
    assign cfg_o.coarse = coarse_reg;
    assign cfg_o.inner  = inner_reg;
    assign cfg_o.ds     = ds_reg;

endmodule

// ===== hw/rtl/tsm_isqrt.sv =====
// ----------------------------------------------------------------------------
// tsm_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tsm_isqrt #(
    parameter int IN_W = tsm_pkg::RAD_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_rad,
    output logic              out_valid,
    output logic [IN_W/2-1:0] out_root
);
    import tsm_pkg::*;

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;
    localparam int NS    = OUT_W;

    logic              v_reg    [NS];
    logic [IN_W-1:0]   rad_reg  [NS];
    logic [REM_W-1:0]  rem_reg  [NS];
    logic [OUT_W-1:0]  root_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic              v_src;
        logic [IN_W-1:0]   rad_src;
        logic [REM_W-1:0]  rem_src, rem_sh, trial;
        logic [OUT_W-1:0]  root_src;
        logic              ge;

        if (s == 0) begin : g_first
            assign v_src    = in_valid;
            assign rad_src  = in_rad;
            assign rem_src  = '0;
            assign root_src = '0;
        end else begin : g_next
            assign v_src    = v_reg[s-1];
            assign rad_src  = rad_reg[s-1];
            assign rem_src  = rem_reg[s-1];
            assign root_src = root_reg[s-1];
        end

        assign rem_sh = {rem_src[REM_W-3:0], rad_src[IN_W-1:IN_W-2]};
        assign trial  = {root_src, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[s]  <= {rad_src[IN_W-3:0], 2'b00};
                rem_reg[s]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[s] <= {root_src[OUT_W-2:0], ge};
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1];

endmodule

// ===== hw/rtl/tsm_front.sv =====
// ----------------------------------------------------------------------------
// tsm_front
// Accepts points, measures both distances and classifies the region.
// ----------------------------------------------------------------------------
module tsm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [tsm_pkg::PT_W-1:0] s_point_x,
    input  logic signed [tsm_pkg::PT_W-1:0] s_point_y,
    input  logic signed [tsm_pkg::PT_W-1:0] s_point_z,
    input  tsm_pkg::tsm_cfg_t             cfg_i,
    input  logic                          busy_i,
    input  logic                          full_i,
    output logic                          push_o,
    output tsm_pkg::tsm_item_t            item_o
);
    import tsm_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [PT_W-1:0] p,
                                                   input logic signed [PT_W-1:0] c);
        logic signed [DIFF_W-1:0] d;
        d = {p[PT_W-1], p} - {c[PT_W-1], c};
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic en, acc;
    logic v0_reg, v1_reg, v2_reg, c_valid_reg;
    logic [DIFF_W-1:0] ds_reg [3];
    logic [DIFF_W-1:0] db_reg [3];
    logic [SQ_W-1:0]   qs_reg [3];
    logic [SQ_W-1:0]   qb_reg [3];
    logic [RAD_W-1:0]  rad_s_reg, rad_b_reg;
    logic              rs_valid, rb_valid;
    logic [ROOT_W-1:0] rs, rb, a_ext, b_ext, din, dout;
    tsm_item_t         item_c, item_reg;

    assign en      = !c_valid_reg || !full_i;
    assign s_ready = en && !busy_i;
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= acc;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            c_valid_reg <= rs_valid && rb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ds_reg[0] <= abs_diff(s_point_x, cfg_i.cx);
            ds_reg[1] <= abs_diff(s_point_y, cfg_i.cy);
            ds_reg[2] <= abs_diff(s_point_z, cfg_i.cz);
            db_reg[0] <= abs_diff(s_point_x, '0);
            db_reg[1] <= abs_diff(s_point_y, '0);
            db_reg[2] <= abs_diff(s_point_z, '0);
            for (int i = 0; i < 3; i++) begin
                qs_reg[i] <= {{DIFF_W{1'b0}}, ds_reg[i]} * {{DIFF_W{1'b0}}, ds_reg[i]};
                qb_reg[i] <= {{DIFF_W{1'b0}}, db_reg[i]} * {{DIFF_W{1'b0}}, db_reg[i]};
            end
            rad_s_reg <= RAD_W'(qs_reg[0]) + RAD_W'(qs_reg[1]) + RAD_W'(qs_reg[2]);
            rad_b_reg <= RAD_W'(qb_reg[0]) + RAD_W'(qb_reg[1]) + RAD_W'(qb_reg[2]);
            item_reg  <= item_c;
        end
    end

    tsm_isqrt #(.IN_W(RAD_W)) u_sqrt_s (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .in_rad(rad_s_reg), .out_valid(rs_valid), .out_root(rs)
    );

    tsm_isqrt #(.IN_W(RAD_W)) u_sqrt_b (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .in_rad(rad_b_reg), .out_valid(rb_valid), .out_root(rb)
    );

    assign a_ext = ROOT_W'(cfg_i.a);
    assign b_ext = ROOT_W'(cfg_i.b);
    assign din   = a_ext - rs;
    assign dout  = rs - a_ext;

    always_comb begin
        item_c.is_ramp = 1'b0;
        item_c.num     = '0;
        item_c.lo      = cfg_i.fine;
        item_c.hi      = cfg_i.coarse;
        priority if (rb >= b_ext) begin
            item_c.hi = cfg_i.coarse;
        end else if (rs < a_ext) begin
            item_c.hi      = cfg_i.inner;
            item_c.num     = din;
            item_c.is_ramp = DS_W'(din) <= cfg_i.ds;
        end else begin
            item_c.num     = dout;
            item_c.is_ramp = DS_W'(dout) <= cfg_i.ds;
        end
    end

    assign push_o = c_valid_reg && !full_i;
    assign item_o = item_reg;

endmodule

// ===== hw/rtl/tsm_fifo.sv =====
// ----------------------------------------------------------------------------
// tsm_fifo
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module tsm_fifo #(
    parameter int WIDTH = $bits(tsm_pkg::tsm_item_t),
    parameter int DEPTH = tsm_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);
    import tsm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = cnt_reg == CNT_W'(DEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tsm_back.sv =====
// ----------------------------------------------------------------------------
// tsm_back
// Band fraction divider, ramp multiply and result register.
// ----------------------------------------------------------------------------
module tsm_back #(
    parameter int FRAC_BITS = tsm_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tsm_pkg::tsm_item_t          item_i,
    input  logic                        empty_i,
    output logic                        pop_o,
    input  logic [tsm_pkg::DS_W-1:0]    ds_i,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tsm_pkg::SZ_W-1:0]    m_mesh_size
);
    import tsm_pkg::*;

    localparam int T_W  = FRAC_BITS + 1;
    localparam int PR_W = SZ_W + T_W;
    localparam int NS   = FRAC_BITS + 1;

    logic en;

    // stage 0 is the pop register, stages 1..FRAC_BITS one quotient bit each
    logic                 v_reg    [NS];
    tsm_item_t            it_reg   [NS];
    logic                 zero_reg [NS];
    logic                 one_reg  [NS];
    logic [FRAC_BITS-1:0] q_reg    [NS];
    logic [DS_W-1:0]      rem_reg  [NS];

    logic              mv_reg, mup_reg, mramp_reg;
    logic [SZ_W-1:0]   mlo_reg, mhi_reg;
    logic [PR_W-1:0]   mprod_reg;
    logic [T_W-1:0]    t_c;
    logic [SZ_W-1:0]   diff_c, step_c;
    logic              up_c;
    logic              out_v_reg;
    logic [SZ_W-1:0]   out_reg;
    tsm_item_t         last_it;

    assign en    = !out_v_reg || m_ready;
    assign pop_o = en && !empty_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= pop_o;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it_reg[0]   <= item_i;
            zero_reg[0] <= ds_i == '0;
            one_reg[0]  <= DS_W'(item_i.num) >= ds_i;
            q_reg[0]    <= '0;
            rem_reg[0]  <= DS_W'(item_i.num);
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_div
        logic [DS_W:0] sh;
        logic          ge;

        assign sh = {rem_reg[s-1], 1'b0};
        assign ge = sh >= {1'b0, ds_i};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                it_reg[s]   <= it_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                one_reg[s]  <= one_reg[s-1];
                q_reg[s]    <= {q_reg[s-1][FRAC_BITS-2:0], ge};
                rem_reg[s]  <= ge ? DS_W'(sh - {1'b0, ds_i}) : sh[DS_W-1:0];
            end
        end
    end

    assign last_it = it_reg[NS-1];

    always_comb begin
        priority if (zero_reg[NS-1]) begin
            t_c = '0;
        end else if (one_reg[NS-1]) begin
            t_c = T_W'(1) << FRAC_BITS;
        end else begin
            t_c = {1'b0, q_reg[NS-1]};
        end
    end

    assign up_c   = last_it.hi >= last_it.lo;
    assign diff_c = up_c ? last_it.hi - last_it.lo : last_it.lo - last_it.hi;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            mv_reg    <= v_reg[NS-1];
            out_v_reg <= mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mprod_reg <= {{T_W{1'b0}}, diff_c} * {{SZ_W{1'b0}}, t_c};
            mup_reg   <= up_c;
            mramp_reg <= last_it.is_ramp;
            mlo_reg   <= last_it.lo;
            mhi_reg   <= last_it.hi;
        end
    end

    assign step_c = SZ_W'(mprod_reg >> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!mramp_reg) begin
                out_reg <= mhi_reg;
            end else if (mup_reg) begin
                out_reg <= mlo_reg + step_c;
            end else begin
                out_reg <= mlo_reg - step_c;
            end
        end
    end

    assign m_valid     = out_v_reg;
    assign m_mesh_size = out_reg;

endmodule

// ===== tb/tb_two_sphere_mesh_size_field.sv =====
// ----------------------------------------------------------------------------
// tb_two_sphere_mesh_size_field
// Self-checking bench for the two-sphere mesh size field. A local predictor
// computes each target size from the live register copy. Every result
// transaction is compared in order against the queue of predicted sizes.
// Directed corners come first, then random points under several register
// settings. Both channels get random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_two_sphere_mesh_size_field;
    import tsm_pkg::*;

    localparam int FB         = 24;
    localparam int LATENCY    = 80;       // nominal pipe delay plus margin
    localparam int CYCLE_MAX  = 600000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [PT_W-1:0] s_point_x = '0;
    logic signed [PT_W-1:0] s_point_y = '0;
    logic signed [PT_W-1:0] s_point_z = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [SZ_W-1:0]        m_mesh_size;

    two_sphere_mesh_size_field dut (.*);

    always #4 aclk = ~aclk;

    // predictor copy of the register file
    logic signed [PT_W-1:0] c_x, c_y, c_z;
    logic [SZ_W-1:0]        r_inner, r_outer, sz_fine, sz_coarse;
    logic [BAND_W-1:0]      band;

    logic [SZ_W-1:0] size_queue[$];
    int              mismatches = 0;
    int              cycles = 0;
    bit              calm = 1'b0;    // no gaps, no stalls while set

    // floor of the square root, result below 2^35
    function automatic logic [69:0] isqrt(input logic [69:0] s);
        logic [69:0] r, c;
        r = '0;
        for (int i = 34; i >= 0; i--) begin
            c = r | (70'd1 << i);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic [69:0] point_dist(input logic signed [31:0] px, py, pz,
                                               input logic signed [31:0] qx, qy, qz);
        longint d[3];
        logic [69:0] m, sum;
        d[0] = longint'(px) - longint'(qx);
        d[1] = longint'(py) - longint'(qy);
        d[2] = longint'(pz) - longint'(qz);
        sum = '0;
        foreach (d[i]) begin
            m = 70'((d[i] < 0) ? -d[i] : d[i]);
            sum += m * m;
        end
        return isqrt(sum);
    endfunction

    // band fraction with FB fraction bits; num never exceeds den here
    function automatic logic [69:0] band_frac(input logic [69:0] num, den);
        if (den == 0) return '0;
        if (num >= den) return 70'd1 << FB;
        return (num << FB) / den;
    endfunction

    function automatic logic [69:0] lerp(input logic [69:0] lo, hi, t);
        if (hi >= lo) return lo + (((hi - lo) * t) >> FB);
        return lo - (((lo - hi) * t) >> FB);
    endfunction

    function automatic logic [SZ_W-1:0] mesh_size_at(input logic signed [31:0] px, py, pz);
        logic [69:0] rs, rb, ds, tgt, res;
        rs  = point_dist(px, py, pz, c_x, c_y, c_z);
        rb  = point_dist(px, py, pz, 0, 0, 0);
        ds  = (70'(band) * r_inner) >> FB;
        tgt = '0;
        if (r_outer != 0) begin
            tgt = (70'(r_inner) * sz_coarse) / r_outer;
            if (tgt > SZ_MAX) tgt = 70'(SZ_MAX);
        end
        if (rb >= r_outer)
            res = 70'(sz_coarse);
        else if (rs < r_inner)
            res = (r_inner - rs <= ds)
                ? lerp(sz_fine, tgt, band_frac(r_inner - rs, ds)) : tgt;
        else
            res = (rs - r_inner <= ds)
                ? lerp(sz_fine, sz_coarse, band_frac(rs - r_inner, ds)) : 70'(sz_coarse);
        return res[SZ_W-1:0];
    endfunction

    function automatic int gap_len();
        if (calm) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // single register write, only while the block is idle; not enforced here
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CX:     c_x = val;
            REG_CY:     c_y = val;
            REG_CZ:     c_z = val;
            REG_INNER:  r_inner = val[SZ_W-1:0];
            REG_OUTER:  r_outer = val[SZ_W-1:0];
            REG_FINE:   sz_fine = val[SZ_W-1:0];
            REG_COARSE: sz_coarse = val[SZ_W-1:0];
            REG_BAND:   band = val[BAND_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] cx, cy, cz, a, b, fine, coarse, bf);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
        write_reg(REG_CZ, cz);
        write_reg(REG_INNER, a);
        write_reg(REG_OUTER, b);
        write_reg(REG_FINE, fine);
        write_reg(REG_COARSE, coarse);
        write_reg(REG_BAND, bf);
    endtask

    // wait until every predicted size has come back, then let the pipe settle
    task automatic drain();
        while (size_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // one point transaction; valid stays up across back-to-back points
    task automatic send_point(input logic signed [31:0] px, py, pz);
        int gap;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        do @(posedge aclk); while (!s_ready);
        size_queue = {size_queue, mesh_size_at(px, py, pz)};
        gap = gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // receiver stalls
    int stall_left = 0;
    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 29) == 0) begin
            stall_left <= $urandom_range(10, 40);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (size_queue.size() == 0) begin
                $display("%0t: unexpected result, actual %0d", $time, m_mesh_size);
                mismatches++;
            end else begin
                logic [SZ_W-1:0] want;
                want = size_queue.pop_front();
                if (m_mesh_size !== want) begin
                    $display("%0t: mesh_size expected %0d actual %0d",
                             $time, want, m_mesh_size);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // reset values: points at the origin, on the small and big spheres
    task automatic test_reset_values();
        send_point(0, 0, 0);
        send_point(32'sd4194304, 0, 0);
        send_point(32'sd6291456, 0, 0);           // end of the band
        send_point(32'sd2097152, 0, 0);           // inner band end
        send_point(0, 32'sd16777215, 0);          // just inside the big sphere
        send_point(0, 0, 32'sd16777216);          // on the big sphere
        end_burst();
        drain();
    endtask

    // field extremes: both corners of the coordinate range
    task automatic test_extremes();
        write_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0400_0000);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        send_point(0, 0, 0);
        end_burst();
        drain();
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        send_point(0, 0, 0);
        send_point(32'sh7fff_ffff, 0, 32'sh8000_0000);
        end_burst();
        drain();
    endtask

    // zero band width: fine size right at the interface
    task automatic test_zero_band();
        write_all(0, 0, 0, 32'd4194304, 32'd16777216, 32'd503316, 32'd5033165, 0);
        send_point(32'sd4194304, 0, 0);
        send_point(32'sd4194305, 0, 0);
        send_point(32'sd4194303, 0, 0);
        end_burst();
        drain();
    endtask

    // zero outer radius: coarse everywhere
    task automatic test_zero_outer();
        write_reg(REG_OUTER, 0);
        send_point(0, 0, 0);
        send_point(32'sd4194304, 0, 0);
        end_burst();
        drain();
    endtask

    // large inner/outer ratio: inner target saturates
    task automatic test_large_ratio();
        write_all(0, 0, 0, 32'h7fff_0000, 32'd1 << 30, 32'd100, 32'h7fff_ffff,
                  32'd1 << 24);
        send_point(32'sd1 << 29, 0, 0);
        send_point(32'sd1 << 20, 0, 0);
        end_burst();
        drain();
    endtask

    function automatic logic signed [31:0] near(input logic signed [31:0] c, input longint r);
        return 32'(longint'(c) + r);
    endfunction

    // random points, mostly close to one of the two sphere surfaces
    task automatic test_random(input int n);
        longint ds, r, j;
        int     ax;
        logic signed [31:0] p[3];
        ds = (longint'(band) * r_inner) >>> FB;
        for (int i = 0; i < n; i++) begin
            ax = $urandom_range(0, 2);
            j  = $urandom_range(0, 4095);
            case ($urandom_range(0, 9))
                0, 1: begin
                    p[0] = $urandom; p[1] = $urandom; p[2] = $urandom;
                end
                2, 3: begin   // near the big sphere
                    r = longint'(r_outer) + longint'($urandom_range(0, 2 * 4096)) - 4096;
                    p[0] = 32'(j); p[1] = 32'(-j); p[2] = 32'(j);
                    p[ax] = ($urandom_range(0, 1)) ? 32'(r) : 32'(-r);
                end
                default: begin  // inside or outside the small sphere, across the band
                    r = longint'(r_inner) +
                        longint'($urandom_range(0, 32'(2 * ds + 8))) - ds - 4;
                    p[0] = near(c_x, j); p[1] = near(c_y, -j); p[2] = near(c_z, j);
                    if (ax == 0) p[0] = near(c_x, $urandom_range(0, 1) ? r : -r);
                    if (ax == 1) p[1] = near(c_y, $urandom_range(0, 1) ? r : -r);
                    if (ax == 2) p[2] = near(c_z, $urandom_range(0, 1) ? r : -r);
                end
            endcase
            send_point(p[0], p[1], p[2]);
        end
        end_burst();
        drain();
    endtask

    task automatic random_config();
        logic [31:0] a, b;
        a = $urandom_range(0, 1 << 26);
        b = $urandom_range(0, 3) ? $urandom_range(a, 1 << 28) : $urandom;
        write_all($urandom_range(0, 1 << 25) - (1 << 24), $urandom_range(0, 1 << 25) - (1 << 24),
                  $urandom_range(0, 1 << 25) - (1 << 24), a, b,
                  $urandom_range(0, 1) ? $urandom_range(0, 1 << 24) : $urandom,
                  $urandom_range(0, 1) ? $urandom_range(0, 1 << 26) : $urandom,
                  $urandom_range(0, 1 << 26));
    endtask

    initial begin
        c_x = '0; c_y = '0; c_z = '0;
        r_inner = RST_INNER; r_outer = RST_OUTER;
        sz_fine = RST_FINE; sz_coarse = RST_COARSE; band = RST_BAND;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        calm = 1'b1;
        test_reset_values();
        calm = 1'b0;
        test_extremes();
        test_zero_band();
        test_zero_outer();
        test_large_ratio();

        // back to reset-like values, then a string of random settings
        write_all(0, 0, 0, RST_INNER, RST_OUTER, RST_FINE, RST_COARSE, RST_BAND);
        test_random(150);
        for (int k = 0; k < 7; k++) begin
            random_config();
            calm = (k == 2);
            test_random(100);
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
